/* rtl/bwsg_pkg.sv */
// Shared types and constants for the block weak-signature generator.
`default_nettype none
package bwsg_pkg;

   localparam int LEN_W      = 21;
   localparam int SUM_W      = 16;
   localparam int CNT_W      = 64;
   localparam int BYTE_W     = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int RSP_DATA_W = 184;

   localparam logic [LEN_W-1:0] LEN_RESET      = 21'd4096;
   localparam logic [31:0]      MAX_BLOCK_SIZE = 32'd1048576;

   // register index, taken from paddr[2]
   localparam logic REG_BLOCK_LENGTH = 1'b0;

   // one finished block; block_number sits in the lowest bits
   typedef struct packed {
      logic [2*SUM_W-1:0] weak_sum;
      logic [LEN_W-1:0]   block_bytes;
      logic [CNT_W-1:0]   block_start;
      logic [CNT_W-1:0]   block_number;
   } result_type;

   typedef struct packed {
      logic       push;
      result_type rec;
   } push_type;

endpackage
`default_nettype wire

/* rtl/bwsg_csr.sv */
// Configuration register: block length and its clamped effective value.
`default_nettype none
module bwsg_csr (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [bwsg_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire  [bwsg_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bwsg_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output logic [bwsg_pkg::LEN_W-1:0]        eff_length
);
   import bwsg_pkg::*;

   logic [LEN_W-1:0] length_ff, length_in;
   logic [LEN_W-1:0] eff_ff, eff_in;
   logic             wr_en;
   logic             sel_len;

   assign csr_pready = 1'b1;
   assign sel_len    = (csr_paddr[2] == REG_BLOCK_LENGTH);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready && sel_len;

   always_comb begin
      length_in = length_ff;
      eff_in    = eff_ff;
      if (wr_en) begin
         length_in = csr_pwdata[LEN_W-1:0];
         if (length_in == '0) begin
            eff_in = LEN_W'(1);
         end else if ({11'd0, length_in} > MAX_BLOCK_SIZE) begin
            eff_in = MAX_BLOCK_SIZE[LEN_W-1:0];
         end else begin
            eff_in = length_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LEN_RESET;
         eff_ff    <= LEN_RESET;
      end else begin
         length_ff <= length_in;
         eff_ff    <= eff_in;
      end
   end

   assign eff_length = eff_ff;
   assign csr_prdata = sel_len ? {11'd0, length_ff} : '0;

endmodule
`default_nettype wire

/* rtl/bwsg_front.sv */
// Front end: takes byte beats, updates the running sums and closes blocks.
`default_nettype none
module bwsg_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              accept,
   input  wire  [bwsg_pkg::BYTE_W-1:0]      data_byte,
   input  wire                              end_of_file,
   input  wire  [bwsg_pkg::LEN_W-1:0]       eff_length,
   output bwsg_pkg::push_type               push_out
);
   import bwsg_pkg::*;

   logic [SUM_W-1:0] sum_a_ff, sum_a_in;
   logic [SUM_W-1:0] sum_b_ff, sum_b_in;
   logic [LEN_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] blk_ff, blk_in;
   logic [CNT_W-1:0] start_ff, start_in;
   logic [SUM_W-1:0] a_new, b_new;
   logic [LEN_W-1:0] count;
   logic             close;

   assign a_new = sum_a_ff + {8'd0, data_byte};
   assign b_new = sum_b_ff + a_new;
   assign count = fill_ff + LEN_W'(1);
   assign close = end_of_file || (count >= eff_length);

   always_comb begin
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      fill_in  = fill_ff;
      blk_in   = blk_ff;
      start_in = start_ff;
      if (accept) begin
         if (!close) begin
            sum_a_in = a_new;
            sum_b_in = b_new;
            fill_in  = count;
         end else begin
            sum_a_in = '0;
            sum_b_in = '0;
            fill_in  = '0;
            if (end_of_file) begin
               blk_in   = '0;
               start_in = '0;
            end else begin
               blk_in   = blk_ff + CNT_W'(1);
               start_in = start_ff + {43'd0, count};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff <= '0;
         sum_b_ff <= '0;
         fill_ff  <= '0;
         blk_ff   <= '0;
         start_ff <= '0;
      end else begin
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         fill_ff  <= fill_in;
         blk_ff   <= blk_in;
         start_ff <= start_in;
      end
   end

   always_comb begin
      push_out.push             = accept && close;
      push_out.rec.block_number = blk_ff;
      push_out.rec.block_start  = start_ff;
      push_out.rec.block_bytes  = count;
      push_out.rec.weak_sum     = {b_new, a_new};
   end

endmodule
`default_nettype wire

/* rtl/bwsg_queue.sv */
// Back end: small result queue whose head drives the result channel.
`default_nettype none
module bwsg_queue #(
   parameter int DEPTH = 4
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire bwsg_pkg::push_type push_in,
   output logic                  full,
   output logic                  out_valid,
   input  wire                   out_ready,
   output bwsg_pkg::result_type  out_rec
);
   import bwsg_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W_Q = $clog2(DEPTH + 1);

   result_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W_Q-1:0]  level_ff, level_in;
   logic                pop;

   assign full      = (level_ff == CNT_W_Q'(DEPTH));
   assign out_valid = (level_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_rec   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push_in.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_in.push && !pop) begin
         level_in = level_ff + CNT_W_Q'(1);
      end else if (pop && !push_in.push) begin
         level_in = level_ff - CNT_W_Q'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         entry_ff[wr_ptr_ff] <= push_in.rec;
      end
   end

endmodule
`default_nettype wire

/* rtl/block_weak_signature_generator_top.sv */
// Block weak-signature generator: per-block rolling checksum over a byte stream.
//
// Input channel (req_*): one file byte per beat in req_tdata[7:0]; req_tlast
// marks the file's last byte and closes a short final block. Bytes are cut
// into blocks of block_length bytes (register at byte address 0 on the csr_*
// port; low 21 bits kept, zero acts as one, values above 1048576 are clamped).
// Result channel (rsp_*): one beat per finished block carrying its index,
// start offset, length and the checksum {b, a}. Counters return to block
// zero, offset zero after an end-of-file byte.
// Throughput: one byte per cycle while the queue has room. The sums are
// updated by two chained 16-bit adds in the front end, and the block offset
// by one 64-bit add, all within the cycle of the byte's beat.
// Latency: the result of a closing byte is visible on rsp_* in the cycle
// after that byte's beat, when the queue is empty.
// Stalls: results wait in a QUEUE_DEPTH-entry queue; req_tready drops only
// while that queue is full, so input flows on while the receiver stalls.
// Reset: synchronous, clears sums, counters and the queue, and loads the
// block length with 4096. No clearing pass; the block is ready at once.
`default_nettype none
module block_weak_signature_generator_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire          clock,
   input  wire          reset,
   // byte stream
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [7:0]   req_tdata,   // [7:0] data_byte
   input  wire          req_tlast,   // end_of_file
   // block results
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [183:0] rsp_tdata,   // [63:0] block_number, [127:64] block_start,
                                     // [148:128] block_bytes, [180:149] weak_sum
   // configuration
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire  [2:0]   csr_paddr,
   input  wire  [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import bwsg_pkg::*;

   logic [LEN_W-1:0] eff_length;
   push_type         push;
   logic             q_full;
   logic             accept;
   result_type       head;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   bwsg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .eff_length  (eff_length)
   );

   // front: accumulate sums, detect block close
   bwsg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_tdata),
      .end_of_file (req_tlast),
      .eff_length  (eff_length),
      .push_out    (push)
   );

   // back: queue of finished blocks feeding the result channel
   bwsg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_in   (push),
      .full      (q_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (head)
   );

   assign rsp_tdata = {3'd0, head};

endmodule
`default_nettype wire

/* rtl/bwsg_checker.sv */
// Port-level checks for the block weak-signature generator, bound to the top.
`default_nettype none
module bwsg_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tvalid,
   input wire         req_tready,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [183:0] rsp_tdata
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // nothing pending right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a block always holds at least one byte
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[148:128] != 21'd0)
      else $error("result with zero block length");

   // a fresh result needs a byte beat on the previous edge
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result without a byte beat");

endmodule

bind block_weak_signature_generator_top bwsg_checker u_bwsg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

/* tb/sv/block_checksum_board_pkg.sv */
// Predictor and result checker for the block weak-signature generator bench.
package block_checksum_board_pkg;
   import bwsg_pkg::*;

   class block_checksum_board;
      logic [LEN_W-1:0] length_reg;
      logic [SUM_W-1:0] sum_a;
      logic [SUM_W-1:0] sum_b;
      logic [LEN_W-1:0] bytes_in_block;
      logic [CNT_W-1:0] block_index;
      logic [CNT_W-1:0] block_offset;
      result_type       pending_blocks[$];
      int               mismatches;
      int               bytes_seen;
      int               blocks_checked;

      function new();
         length_reg     = LEN_RESET;
         sum_a          = '0;
         sum_b          = '0;
         bytes_in_block = '0;
         block_index    = '0;
         block_offset   = '0;
         mismatches     = 0;
         bytes_seen     = 0;
         blocks_checked = 0;
      endfunction

      // register keeps only its low 21 bits
      function void set_length(logic [31:0] value);
         length_reg = value[LEN_W-1:0];
      endfunction

      // one accepted byte; queues a finished block when this byte closes one
      function void take_byte(logic [7:0] data, logic eof);
         logic [LEN_W:0] limit;
         logic [LEN_W:0] count;
         result_type     blk;
         limit = {1'b0, length_reg};
         if (limit == 0) limit = 1;
         if (limit > MAX_BLOCK_SIZE) limit = MAX_BLOCK_SIZE[LEN_W:0];
         bytes_seen++;
         sum_a = sum_a + data;
         sum_b = sum_b + sum_a;
         count = bytes_in_block + 1'b1;
         if (!eof && count < limit) begin
            bytes_in_block = count[LEN_W-1:0];
            return;
         end
         blk.block_number = block_index;
         blk.block_start  = block_offset;
         blk.block_bytes  = count[LEN_W-1:0];
         blk.weak_sum     = {sum_b, sum_a};
         pending_blocks   = {pending_blocks, blk};
         sum_a          = '0;
         sum_b          = '0;
         bytes_in_block = '0;
         // end of file starts the next file at block zero, offset zero
         if (eof) begin
            block_index  = '0;
            block_offset = '0;
         end else begin
            block_index  = block_index + 1'b1;
            block_offset = block_offset + count;
         end
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void match_block(result_type got);
         result_type want;
         if (pending_blocks.size() == 0) begin
            $error("block result with no closing byte behind it: %p", got);
            mismatches++;
            return;
         end
         want = pending_blocks.pop_front();
         blocks_checked++;
         check_field("block_number", want.block_number, got.block_number);
         check_field("block_start", want.block_start, got.block_start);
         check_field("block_bytes", 64'(want.block_bytes), 64'(got.block_bytes));
         check_field("weak_sum", 64'(want.weak_sum), 64'(got.weak_sum));
      endfunction
   endclass

endpackage

/* tb/sv/tb_top.sv */
// Top-level bench: drives bytes and block-length writes, checks block checksums.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bwsg_pkg::*;
   import block_checksum_board_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;     // long receiver stall
   localparam int IDLE_PCT    = 28;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;    // [7:0] data_byte
   logic         req_tlast;    // end_of_file
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [183:0] rsp_tdata;    // [63:0] block_number, [127:64] block_start,
                               // [148:128] block_bytes, [180:149] weak_sum
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   block_checksum_board board;
   int          cycle_count = 0;
   bit          src_gaps    = 1'b1;   // sender may idle
   bit          sink_gaps   = 1'b1;   // receiver may stall
   bit          hold_request = 1'b0;  // ask the receiver for one long stall

   block_weak_signature_generator_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // watchdog: a hung handshake or a missing block ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // input monitor: every accepted byte beat feeds the predictor
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) board.take_byte(req_tdata, req_tlast);
   end

   // output monitor: every accepted result beat is checked against the oldest block
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.match_block(rsp_tdata[$bits(result_type)-1:0]);
   end

   // receiver: random back-pressure, plus one long hold-off on request so the
   // result queue fills and req_tready drops
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= !(sink_gaps && $urandom_range(99) < IDLE_PCT);
      end
   end

   // one byte beat; returns at the edge that accepted it
   task automatic send_byte(input logic [7:0] data, input logic eof);
      while (src_gaps && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= eof;
      do @(posedge clock); while (!req_tready);
   endtask

   // sender goes quiet until every predicted block has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending_blocks.size() != 0) @(posedge clock);
      // a byte that closes nothing may still be in the front end
      repeat (3) @(posedge clock);
   endtask

   // two-phase APB write of block_length; only called with the block idle
   task automatic csr_write(input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_BLOCK_LENGTH, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.set_length(value);
      // register reads back its low 21 bits
      @(posedge clock);
      board.check_field("block_length", 64'(value[LEN_W-1:0]), 64'(csr_prdata));
   endtask

   // one random file run at a given block length; last beat always closes the file
   task automatic run_phase(input logic [31:0] length, input int beats,
                            input int eof_pct, input bit heavy);
      logic [7:0] data;
      csr_write(length);
      for (int i = 0; i < beats; i++) begin
         data = heavy ? 8'($urandom_range(255, 200)) : 8'($urandom_range(255));
         send_byte(data, (i == beats - 1) || ($urandom_range(99) < eof_pct));
      end
      drain_results();
   endtask

   initial begin
      board = new();
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // reset length 4096: short file closed by end of file
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b1);
      drain_results();

      // zero length acts as one: every byte is a block, eof restarts at zero
      csr_write(32'd0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b1);
      drain_results();

      // all-ones write: masked to 21 bits then clamped to the maximum
      csr_write(32'hFFFF_FFFF);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hFE, 1'b1);
      drain_results();

      // exactly the maximum
      csr_write(MAX_BLOCK_SIZE);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b1);
      drain_results();

      // bit above the register width is dropped: acts as length 3
      csr_write(32'h0020_0003);
      send_byte(8'h10, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'h40, 1'b0);
      send_byte(8'h08, 1'b1);
      drain_results();

      // length shrinks under an open block: the next byte closes it
      csr_write(32'd100);
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b0);
      send_byte(8'h44, 1'b0);
      send_byte(8'h55, 1'b0);
      drain_results();
      csr_write(32'd2);
      send_byte(8'h66, 1'b0);
      send_byte(8'h77, 1'b0);
      send_byte(8'h88, 1'b1);
      drain_results();

      // --- random ---
      run_phase(32'd1, 50, 10, 1'b0);

      // stretch with no idling on either side
      src_gaps  = 1'b0;
      sink_gaps = 1'b0;
      run_phase(32'd2, 60, 5, 1'b0);

      // receiver holds off while bytes keep coming: queue fills, input stalls
      sink_gaps    = 1'b1;
      hold_request = 1'b1;
      run_phase(32'd1, 40, 10, 1'b0);
      src_gaps = 1'b1;

      run_phase(32'd7, 80, 3, 1'b0);
      run_phase(32'd16, 80, 2, 1'b0);
      run_phase(32'($urandom_range(40, 3)), 80, 4, 1'b0);
      // long block of high bytes so both 16-bit sums wrap
      run_phase(32'd300, 320, 0, 1'b1);

      $display("Sent %0d bytes, checked %0d blocks; lengths 1 to 1048576, zero and oversize",
               board.bytes_seen, board.blocks_checked);
      $display("writes, a mid-block length change, end-of-file restarts, sum wrap, long stall.");
      if (board.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/bwsg_pkg.sv
rtl/bwsg_csr.sv
rtl/bwsg_front.sv
rtl/bwsg_queue.sv
rtl/block_weak_signature_generator_top.sv
rtl/bwsg_checker.sv
tb/sv/block_checksum_board_pkg.sv
tb/sv/tb_top.sv
